// ===== src/gtpul_pkg.sv =====
package gtpul_pkg;

   localparam logic [15:0] MAX_FRAME_BYTES   = 16'd65535;
   localparam int unsigned LINK_HEADER_BYTES = 14;
   localparam int unsigned HEND_W            = 17;

   typedef enum logic [3:0] {
      LAYER_IDLE = 4'd0,
      LAYER_LINK = 4'd1,
      LAYER_OIP  = 4'd2,
      LAYER_UDP  = 4'd3,
      LAYER_GTP  = 4'd4,
      LAYER_GTPE = 4'd5,
      LAYER_EXT  = 4'd6,
      LAYER_IIP  = 4'd7,
      LAYER_TCP  = 4'd8,
      LAYER_PAY  = 4'd9
   } layer_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_TRUNC = 2'd1,
      STAT_BAD   = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       end_of_frame;
   } beat_type;

   typedef struct packed {
      status_type  parse_status;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
   } result_type;

endpackage

// ===== src/gtpul_if.sv =====
interface gtpul_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       end_of_frame;

   modport source(output valid, output frame_byte, output end_of_frame, input ready);
   modport sink(input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface gtpul_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  parse_status;
   logic [15:0] payload_offset;
   logic [15:0] payload_length;

   modport source(output valid, output parse_status, output payload_offset,
                  output payload_length, input ready);
   modport sink(input valid, input parse_status, input payload_offset,
                input payload_length, output ready);
endinterface

// ===== src/gtpul_walker.sv =====
module gtpul_walker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_valid,
   input  gtpul_pkg::beat_type  beat,
   input  logic                 encap_mode,
   output gtpul_pkg::result_type result
);
   import gtpul_pkg::*;

   localparam logic [HEND_W-1:0] IP_MIN_BYTES  = HEND_W'(20);
   localparam logic [HEND_W-1:0] UDP_BYTES     = HEND_W'(8);
   localparam logic [HEND_W-1:0] GTP_BYTES     = HEND_W'(8);
   localparam logic [HEND_W-1:0] GTP_OPT_BYTES = HEND_W'(12);
   localparam logic [HEND_W-1:0] EXT_MIN_BYTES = HEND_W'(4);
   localparam logic [HEND_W-1:0] TCP_OFF_BYTE  = HEND_W'(12);
   localparam logic [3:0]        MIN_WORDS     = 4'd5;

   function automatic logic [HEND_W-1:0] min_len(input layer_type l);
      logic [HEND_W-1:0] m;
      begin
         unique case (l) inside
            LAYER_LINK: m = HEND_W'(LINK_HEADER_BYTES);
            LAYER_OIP, LAYER_IIP, LAYER_TCP: m = IP_MIN_BYTES;
            LAYER_UDP: m = UDP_BYTES;
            LAYER_GTP: m = GTP_BYTES;
            LAYER_EXT: m = EXT_MIN_BYTES;
            default: m = '0;
         endcase
         return m;
      end
   endfunction

   layer_type         layer_ff, layer_in;
   logic [15:0]       pos_ff, pos_in;
   logic [HEND_W-1:0] hend_ff, hend_in;
   status_type        err_ff, err_in;
   logic [15:0]       pstart_ff, pstart_in;

   layer_type         l0, l1, nxt, upd_layer;
   logic [15:0]       ps0, upd_pos, upd_pstart;
   logic [HEND_W-1:0] he0, he1, ps0_x, upd_hend;
   status_type        upd_err;
   logic              rel0, rel12, bad, go;
   logic [7:0]        b;

   assign b     = beat.frame_byte;
   assign ps0_x = {1'b0, ps0};
   assign rel0  = (pos_ff == ps0);
   assign rel12 = ({1'b0, pos_ff} == ps0_x + TCP_OFF_BYTE);

   always_comb begin
      l0  = layer_ff;
      ps0 = pstart_ff;
      he0 = hend_ff;
      if (layer_ff == LAYER_IDLE) begin
         ps0 = '0;
         if (encap_mode && (LINK_HEADER_BYTES > 0)) begin
            l0  = LAYER_LINK;
            he0 = HEND_W'(LINK_HEADER_BYTES);
         end else begin
            l0  = encap_mode ? LAYER_OIP : LAYER_IIP;
            he0 = IP_MIN_BYTES;
         end
      end
   end

   always_comb begin
      l1  = l0;
      he1 = he0;
      bad = 1'b0;
      unique case (l0) inside
         LAYER_OIP, LAYER_IIP: begin
            if (rel0) begin
               if (b[3:0] < MIN_WORDS) bad = 1'b1;
               else he1 = ps0_x + HEND_W'({b[3:0], 2'b00});
            end
         end
         LAYER_GTP: begin
            if (rel0) begin
               if (b[2:0] != 3'd0) he1 = ps0_x + GTP_OPT_BYTES;
               if (b[2]) l1 = LAYER_GTPE;
            end
         end
         LAYER_EXT: begin
            if (rel0) begin
               if (b == 8'd0) bad = 1'b1;
               else he1 = ps0_x + HEND_W'({b, 2'b00});
            end
         end
         LAYER_TCP: begin
            if (rel12) begin
               if (b[7:4] < MIN_WORDS) bad = 1'b1;
               else he1 = ps0_x + HEND_W'({b[7:4], 2'b00});
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      go = !bad && (l1 != LAYER_PAY) && (({1'b0, pos_ff} + HEND_W'(1)) == he1);
      unique case (l1) inside
         LAYER_LINK: nxt = LAYER_OIP;
         LAYER_OIP:  nxt = LAYER_UDP;
         LAYER_UDP:  nxt = LAYER_GTP;
         LAYER_GTP:  nxt = LAYER_IIP;
         LAYER_GTPE, LAYER_EXT: nxt = (b != 8'd0) ? LAYER_EXT : LAYER_IIP;
         LAYER_IIP:  nxt = LAYER_TCP;
         default:    nxt = LAYER_PAY;
      endcase
   end

   always_comb begin
      upd_layer  = layer_ff;
      upd_pos    = pos_ff;
      upd_hend   = hend_ff;
      upd_err    = err_ff;
      upd_pstart = pstart_ff;
      if (pos_ff >= MAX_FRAME_BYTES) begin
         if (err_ff == STAT_OK) upd_err = STAT_BAD;
      end else begin
         upd_pos = pos_ff + 16'd1;
         if (err_ff == STAT_OK) begin
            upd_layer  = l1;
            upd_pstart = ps0;
            upd_hend   = he1;
            if (bad) begin
               upd_err = STAT_BAD;
            end else if (go) begin
               upd_layer  = nxt;
               upd_pstart = he1[15:0];
               upd_hend   = he1 + min_len(nxt);
            end
         end
      end

      layer_in  = layer_ff;
      pos_in    = pos_ff;
      hend_in   = hend_ff;
      err_in    = err_ff;
      pstart_in = pstart_ff;
      if (step_valid) begin
         if (beat.end_of_frame) begin
            layer_in  = LAYER_IDLE;
            pos_in    = '0;
            hend_in   = '0;
            err_in    = STAT_OK;
            pstart_in = '0;
         end else begin
            layer_in  = upd_layer;
            pos_in    = upd_pos;
            hend_in   = upd_hend;
            err_in    = upd_err;
            pstart_in = upd_pstart;
         end
      end
   end

   always_comb begin
      result.parse_status   = STAT_OK;
      result.payload_offset = '0;
      result.payload_length = '0;
      if (upd_err != STAT_OK) begin
         result.parse_status = upd_err;
      end else if (upd_layer != LAYER_PAY) begin
         result.parse_status = STAT_TRUNC;
      end else if (upd_pos <= upd_pstart) begin
         result.parse_status = STAT_EMPTY;
      end else begin
         result.payload_offset = upd_pstart;
         result.payload_length = upd_pos - upd_pstart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff  <= LAYER_IDLE;
         pos_ff    <= '0;
         hend_ff   <= '0;
         err_ff    <= STAT_OK;
         pstart_ff <= '0;
      end else begin
         layer_ff  <= layer_in;
         pos_ff    <= pos_in;
         hend_ff   <= hend_in;
         err_ff    <= err_in;
         pstart_ff <= pstart_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step_valid && beat.end_of_frame |=> layer_ff == LAYER_IDLE && pos_ff == 16'd0
         && err_ff == STAT_OK)
      else $error("walker state not cleared after last beat");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff != STAT_OK && !(step_valid && beat.end_of_frame) |=> err_ff == $past(err_ff))
      else $error("latched error changed within a frame");

   a_payload_behind_pos: assert property (@(posedge clock) disable iff (reset)
      layer_ff == LAYER_PAY |-> pstart_ff <= pos_ff)
      else $error("payload start beyond byte position");

   a_not_ok_zero: assert property (@(posedge clock) disable iff (reset)
      result.parse_status != STAT_OK |-> result.payload_offset == 16'd0
         && result.payload_length == 16'd0)
      else $error("nonzero offset or length on a failed frame");

endmodule

// ===== src/gtpu_tcp_payload_locator.sv =====
// Locates the TCP payload in a frame delivered one byte per beat. In encapsulated mode
// (csr bit set, the reset value) the walk is a 14-byte link header, outer IPv4, UDP,
// GTP-U with its extension chain, inner IPv4 and TCP; with the bit clear it is IPv4 then
// TCP. The mode is sampled at the first byte of a frame. Only the beat marked as the last
// one yields a result beat: status (ok, truncated, malformed, empty payload), payload
// offset and length, the latter two zero unless ok. The block sustains one byte per clock
// with no gaps except while a last byte waits, as below; each byte is held in an input
// register and walked from there, and a walked last byte puts its result in the output
// register. Bytes keep flowing while that result waits for the sink, up to the next last
// byte, which is held in the input register until the output register frees.
module gtpu_tcp_payload_locator (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   gtpul_req_if.sink   req_chan,
   gtpul_rsp_if.source rsp_chan
);
   import gtpul_pkg::*;

   logic       mode_ff, mode_in;
   logic       s1_valid_ff, s1_valid_in;
   beat_type   s1_beat_ff, s1_beat_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   result_type walk_result;
   logic       out_free, adv, take, emit;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign adv      = s1_valid_ff && (!s1_beat_ff.end_of_frame || out_free);
   assign emit     = adv && s1_beat_ff.end_of_frame;
   assign take     = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || adv;

   gtpul_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .step_valid (adv),
      .beat       (s1_beat_ff),
      .encap_mode (mode_ff),
      .result     (walk_result)
   );

   always_comb begin
      mode_in = csr_wr_en ? csr_wr_data : mode_ff;

      s1_beat_in = s1_beat_ff;
      if (take) begin
         s1_valid_in             = 1'b1;
         s1_beat_in.frame_byte   = req_chan.frame_byte;
         s1_beat_in.end_of_frame = req_chan.end_of_frame;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      rsp_in = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = walk_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_beat_ff <= s1_beat_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.parse_status   = rsp_ff.parse_status;
   assign rsp_chan.payload_offset = rsp_ff.payload_offset;
   assign rsp_chan.payload_length = rsp_ff.payload_length;

endmodule
